FILE: rtl/bb3c_pkg.sv
// ============================================================================
// bb3c_pkg
// Shared constants, types and helpers of the clipped 3x3 box blur.
// ============================================================================
package bb3c_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int MAX_DIM      = 1024;
  localparam int MIN_DIM      = 2;
  localparam int DIM_W        = $clog2(MAX_DIM);
  localparam int FIELD_W      = 16;
  localparam int CFG_W        = 11;
  localparam int POS_W        = 10;
  localparam int CMP_W        = (CFG_W > DIM_W + 1) ? CFG_W : DIM_W + 1;
  localparam int COL_W        = CHANNEL_BITS + 2;
  localparam int SUM_W        = CHANNEL_BITS + 4;
  localparam int RECIP_SHIFT  = SUM_W + 4;
  localparam int MUL_W        = RECIP_SHIFT - 1;
  localparam int PROD_W       = SUM_W + MUL_W;
  localparam int NUM_KINDS    = 4;

  localparam logic [MUL_W-1:0] RECIP4 = MUL_W'(64'd1 << (RECIP_SHIFT - 2));
  localparam logic [MUL_W-1:0] RECIP6 = MUL_W'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6);
  localparam logic [MUL_W-1:0] RECIP9 = MUL_W'(((64'd1 << RECIP_SHIFT) + 64'd8) / 64'd9);

  localparam int APB_DW    = 32;
  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_DIM   = REG_IDX_W'(0);
  localparam logic [CFG_W-1:0]     FRAME_DIM_RESET = CFG_W'(512);

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  localparam int KIND_MAIN   = 0;
  localparam int KIND_RIGHT  = 1;
  localparam int KIND_BOTTOM = 2;
  localparam int KIND_CORNER = 3;

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [2:0][CHANNEL_BITS-1:0] rgb_t;
  typedef logic [2:0][COL_W-1:0] csum_t;
  typedef csum_t [2:0] win_cols_t;

  typedef struct packed {
    rgb_t newer;
    rgb_t older;
  } line_entry_t;

  typedef struct packed {
    win_cols_t full;
    win_cols_t bottom;
  } window_t;

  typedef struct packed {
    dim_t dim_last;
    logic restart;
  } cfg_t;

  typedef enum logic [1:0] {
    DIV4,
    DIV6,
    DIV9
  } div_t;

  typedef struct packed {
    logic [NUM_KINDS-1:0] kinds;
    logic                 full;
    logic                 rows3;
    dim_t                 row;
    dim_t                 col;
  } batch_t;

  typedef struct packed {
    logic   valid;
    batch_t batch;
  } batch_link_t;

  typedef struct packed {
    logic [2:0][SUM_W-1:0] sum;
    div_t                  div;
    dim_t                  row;
    dim_t                  col;
    logic                  last;
    logic                  done;
  } sum_item_t;

  function automatic dim_t eff_last(input logic [CFG_W-1:0] frame_dim);
    logic [CMP_W-1:0] f;
    f = CMP_W'(frame_dim);
    if (f < CMP_W'(MIN_DIM)) begin
      return DIM_W'(MIN_DIM - 1);
    end else if (f > CMP_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM - 1);
    end else begin
      return DIM_W'(f - CMP_W'(1));
    end
  endfunction

endpackage

FILE: rtl/bb3c_if.sv
// ============================================================================
// bb3c_if
// Pixel and result channels of the clipped 3x3 box blur.
// ============================================================================
interface bb3c_pixel_if;
  import bb3c_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] in_red;
  logic [FIELD_W-1:0] in_green;
  logic [FIELD_W-1:0] in_blue;

  modport source (output valid, in_red, in_green, in_blue, input ready);
  modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface bb3c_result_if;
  import bb3c_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] out_red;
  logic [FIELD_W-1:0] out_green;
  logic [FIELD_W-1:0] out_blue;
  logic [POS_W-1:0]   out_row;
  logic [POS_W-1:0]   out_col;
  logic               last_of_run;
  logic               frame_done;

  modport source (output valid, out_red, out_green, out_blue, out_row, out_col,
                  last_of_run, frame_done, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_row, out_col,
                last_of_run, frame_done, output ready);
endinterface

FILE: rtl/box_blur_3x3_clipped_top.sv
// ============================================================================
// box_blur_3x3_clipped_top
// Streaming 3x3 mean filter, clipped to a square RGB frame.
// ============================================================================
// Pixels enter in raster order at one per clock while ready is high. Each pixel
// yields one result item in the interior of the frame and none in row 0 or
// column 0, the last pixel of a row yields two, each pixel of the last row two,
// and the last pixel of the frame four. Result items leave at one per clock
// while the sink is ready; while the emitter walks the items of a pixel, the
// next pixel waits in the column stage and holds the input. A pixel's results
// pass through the column stage, the emitter's batch and item registers and
// the output register. The two rows above are kept in one line store memory
// indexed by column, read when a pixel is accepted and written back when the
// pixel moves on. Entries are used only after they have been written in the
// current frame, so the store needs no clearing pass after reset. A write to
// the frame side register restarts the frame at row 0, column 0; a side below
// 2 acts as 2 and a side above the store depth acts as the store depth.
module box_blur_3x3_clipped_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bb3c_pkg::PADDR_W-1:0]  paddr,
  input  logic [bb3c_pkg::APB_DW-1:0]   pwdata,
  output logic [bb3c_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  bb3c_pixel_if.sink                    pixel,
  bb3c_result_if.source                 result
);
  import bb3c_pkg::*;

  cfg_t        cfg;
  window_t     window;
  batch_link_t link;
  logic        load_ready;
  sum_item_t   item;
  logic        item_valid;
  logic        item_ready;

  bb3c_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bb3c_column u_column (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pixel      (pixel),
    .window     (window),
    .link       (link),
    .load_ready (load_ready)
  );

  bb3c_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .window     (window),
    .link       (link),
    .load_ready (load_ready),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  bb3c_divide u_divide (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .result     (result)
  );

  a_done_at_corner: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.frame_done |->
      result.last_of_run && result.out_row == POS_W'(cfg.dim_last) &&
      result.out_col == POS_W'(cfg.dim_last))
    else $error("frame_done away from the last corner or not last of its run");

  a_batch_to_free_emitter: assert property (@(posedge clk) disable iff (rst)
    link.valid |-> load_ready)
    else $error("result batch handed to a busy emitter");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && !result.last_of_run |=> result.valid)
    else $error("gap inside a run of result items");

endmodule

FILE: rtl/bb3c_cfg.sv
// ============================================================================
// bb3c_cfg
// APB register file holding the frame side and its clamped last index.
// ============================================================================
module bb3c_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bb3c_pkg::PADDR_W-1:0]  paddr,
  input  logic [bb3c_pkg::APB_DW-1:0]   pwdata,
  output logic [bb3c_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output bb3c_pkg::cfg_t                cfg
);
  import bb3c_pkg::*;

  logic [CFG_W-1:0]     frame_dim;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_dim <= FRAME_DIM_RESET;
    end else if (wr_en && reg_idx == REG_FRAME_DIM) begin
      frame_dim <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata       = (reg_idx == REG_FRAME_DIM) ? APB_DW'(frame_dim) : '0;
  assign cfg.dim_last = eff_last(frame_dim);
  assign cfg.restart  = wr_en && reg_idx == REG_FRAME_DIM;

endmodule

FILE: rtl/bb3c_column.sv
// ============================================================================
// bb3c_column
// Raster counters, line store read-modify-write and the column sum window.
// ============================================================================
module bb3c_column (
  input  logic                  clk,
  input  logic                  rst,
  input  bb3c_pkg::cfg_t        cfg,
  bb3c_pixel_if.sink            pixel,
  output bb3c_pkg::window_t     window,
  output bb3c_pkg::batch_link_t link,
  input  logic                  load_ready
);
  import bb3c_pkg::*;

  dim_t        row;
  dim_t        col;
  logic        b_valid;
  rgb_t        b_px;
  dim_t        b_row;
  dim_t        b_col;
  line_entry_t mem [MAX_DIM];
  line_entry_t rd;
  window_t     win;
  logic        accept;
  logic        b_go;
  rgb_t        up;
  rgb_t        up2;
  csum_t       cs_full;
  csum_t       cs_bottom;
  logic        r_ge1;
  logic        r_ge2;
  logic        c_ge1;
  logic        c_ge2;
  logic        r_last;
  logic        c_last;

  assign pixel.ready = !b_valid || load_ready;
  assign accept      = pixel.valid && pixel.ready;
  assign b_go        = b_valid && load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      col     <= '0;
      b_valid <= 1'b0;
    end else begin
      if (cfg.restart) begin
        row <= '0;
        col <= '0;
      end else if (accept) begin
        if (col == cfg.dim_last) begin
          col <= '0;
          row <= (row == cfg.dim_last) ? '0 : row + DIM_W'(1);
        end else begin
          col <= col + DIM_W'(1);
        end
      end
      if (accept) begin
        b_valid <= 1'b1;
      end else if (b_go) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_px[CH_RED]   <= pixel.in_red[CHANNEL_BITS-1:0];
      b_px[CH_GREEN] <= pixel.in_green[CHANNEL_BITS-1:0];
      b_px[CH_BLUE]  <= pixel.in_blue[CHANNEL_BITS-1:0];
      b_row          <= row;
      b_col          <= col;
    end
  end

  // The row above moves to the older slot while the new pixel takes its place.
  always_ff @(posedge clk) begin
    if (b_go) begin
      mem[b_col] <= '{newer: b_px, older: rd.newer};
    end
    if (accept) begin
      rd <= mem[col];
    end
  end

  assign r_ge1  = b_row != '0;
  assign r_ge2  = b_row > DIM_W'(1);
  assign c_ge1  = b_col != '0;
  assign c_ge2  = b_col > DIM_W'(1);
  assign r_last = b_row == cfg.dim_last;
  assign c_last = b_col == cfg.dim_last;

  always_comb begin
    up  = r_ge1 ? rd.newer : '0;
    up2 = r_ge2 ? rd.older : '0;
    for (int i = 0; i < 3; i++) begin
      cs_bottom[i] = COL_W'(b_px[i]) + COL_W'(up[i]);
      cs_full[i]   = cs_bottom[i] + COL_W'(up2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      win.full[0]   <= win.full[1];
      win.full[1]   <= win.full[2];
      win.full[2]   <= cs_full;
      win.bottom[0] <= win.bottom[1];
      win.bottom[1] <= win.bottom[2];
      win.bottom[2] <= cs_bottom;
    end
  end

  assign window = win;

  always_comb begin
    link.valid                    = b_go && r_ge1 && c_ge1;
    link.batch.kinds[KIND_MAIN]   = 1'b1;
    link.batch.kinds[KIND_RIGHT]  = c_last;
    link.batch.kinds[KIND_BOTTOM] = r_last;
    link.batch.kinds[KIND_CORNER] = r_last && c_last;
    link.batch.full               = c_ge2;
    link.batch.rows3              = r_ge2;
    link.batch.row                = b_row;
    link.batch.col                = b_col;
  end

endmodule

FILE: rtl/bb3c_emit.sv
// ============================================================================
// bb3c_emit
// Walks the results of one pixel and forms each neighborhood sum.
// ============================================================================
module bb3c_emit (
  input  logic                  clk,
  input  logic                  rst,
  input  bb3c_pkg::window_t     window,
  input  bb3c_pkg::batch_link_t link,
  output logic                  load_ready,
  output bb3c_pkg::sum_item_t   item,
  output logic                  item_valid,
  input  logic                  item_ready
);
  import bb3c_pkg::*;

  logic                 e_valid;
  batch_t               e_batch;
  logic                 f_valid;
  sum_item_t            f_item;
  logic                 f_ready;
  logic                 e_fire;
  logic [NUM_KINDS-1:0] pick;
  logic                 single;
  logic                 use_w0;
  logic                 use_bottom;
  logic                 upper;
  win_cols_t            cols;
  sum_item_t            next_item;

  assign f_ready    = !f_valid || item_ready;
  assign e_fire     = e_valid && f_ready;
  assign load_ready = !e_valid || (e_fire && single);

  always_comb begin
    pick       = e_batch.kinds & (~e_batch.kinds + NUM_KINDS'(1));
    single     = (e_batch.kinds & (e_batch.kinds - NUM_KINDS'(1))) == '0;
    use_w0     = (pick[KIND_MAIN] || pick[KIND_BOTTOM]) && e_batch.full;
    use_bottom = pick[KIND_BOTTOM] || pick[KIND_CORNER];
    upper      = pick[KIND_MAIN] || pick[KIND_RIGHT];
    cols       = use_bottom ? window.bottom : window.full;
    for (int i = 0; i < 3; i++) begin
      next_item.sum[i] = (use_w0 ? SUM_W'(cols[0][i]) : '0)
                       + SUM_W'(cols[1][i]) + SUM_W'(cols[2][i]);
    end
    priority if (pick[KIND_MAIN]) begin
      if (e_batch.rows3 && e_batch.full) begin
        next_item.div = DIV9;
      end else if (e_batch.rows3 || e_batch.full) begin
        next_item.div = DIV6;
      end else begin
        next_item.div = DIV4;
      end
    end else if (pick[KIND_RIGHT]) begin
      next_item.div = e_batch.rows3 ? DIV6 : DIV4;
    end else if (pick[KIND_BOTTOM]) begin
      next_item.div = e_batch.full ? DIV6 : DIV4;
    end else begin
      next_item.div = DIV4;
    end
    next_item.row  = upper ? e_batch.row - DIM_W'(1) : e_batch.row;
    next_item.col  = (pick[KIND_MAIN] || pick[KIND_BOTTOM]) ?
                     e_batch.col - DIM_W'(1) : e_batch.col;
    next_item.last = single;
    next_item.done = pick[KIND_CORNER];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      f_valid <= 1'b0;
    end else begin
      if (f_ready) begin
        f_valid <= e_valid;
      end
      if (link.valid) begin
        e_valid <= 1'b1;
      end else if (e_fire && single) begin
        e_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_fire) begin
      f_item <= next_item;
    end
    if (link.valid) begin
      e_batch <= link.batch;
    end else if (e_fire) begin
      e_batch.kinds <= e_batch.kinds & ~pick;
    end
  end

  assign item       = f_item;
  assign item_valid = f_valid;

endmodule

FILE: rtl/bb3c_divide.sv
// ============================================================================
// bb3c_divide
// Divides each sum by 4, 6 or 9 and holds the result in the output register.
// ============================================================================
module bb3c_divide (
  input  logic                clk,
  input  logic                rst,
  input  bb3c_pkg::sum_item_t item,
  input  logic                item_valid,
  output logic                item_ready,
  bb3c_result_if.source       result
);
  import bb3c_pkg::*;

  logic                         o_valid;
  logic [2:0][CHANNEL_BITS-1:0] o_mean;
  dim_t                         o_row;
  dim_t                         o_col;
  logic                         o_last;
  logic                         o_done;
  logic [MUL_W-1:0]             recip;
  logic [2:0][PROD_W-1:0]       prod;
  logic [2:0][CHANNEL_BITS-1:0] mean;
  logic                         load;

  assign item_ready = !o_valid || result.ready;
  assign load       = item_valid && item_ready;

  // The reciprocal is exact for every sum the window can produce.
  always_comb begin
    unique case (item.div)
      DIV9:    recip = RECIP9;
      DIV6:    recip = RECIP6;
      DIV4:    recip = RECIP4;
      default: recip = RECIP4;
    endcase
    for (int i = 0; i < 3; i++) begin
      prod[i] = PROD_W'(item.sum[i]) * PROD_W'(recip);
      mean[i] = prod[i][RECIP_SHIFT +: CHANNEL_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (item_ready) begin
      o_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_mean <= mean;
      o_row  <= item.row;
      o_col  <= item.col;
      o_last <= item.last;
      o_done <= item.done;
    end
  end

  assign result.valid       = o_valid;
  assign result.out_red     = FIELD_W'(o_mean[CH_RED]);
  assign result.out_green   = FIELD_W'(o_mean[CH_GREEN]);
  assign result.out_blue    = FIELD_W'(o_mean[CH_BLUE]);
  assign result.out_row     = POS_W'(o_row);
  assign result.out_col     = POS_W'(o_col);
  assign result.last_of_run = o_last;
  assign result.frame_done  = o_done;

endmodule

FILE: sim/box_blur_3x3_clipped_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// box_blur_3x3_clipped_checker
// Watches the pixel, result and register ports of the clipped 3x3 box blur,
// keeps its own copy of the line stores and column sums, works out the result
// items each accepted pixel causes, and compares every result item in order.
// ============================================================================
module box_blur_3x3_clipped_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bb3c_pkg::PADDR_W-1:0]  paddr,
  input  logic [bb3c_pkg::APB_DW-1:0]   pwdata,
  input  logic                          pready,
  bb3c_pixel_if                         pixel,
  bb3c_result_if                        result,
  output int                            errors,
  output int                            pending
);
  import bb3c_pkg::*;

  typedef logic [2:0][31:0] sum3_t;

  typedef struct {
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic               last;
    logic               done;
  } blur_out_t;

  rgb_t              upper_line [MAX_DIM];
  rgb_t              upper2_line [MAX_DIM];
  sum3_t             col_sums [3];
  sum3_t             top_rows [3];
  int unsigned       row_pos;
  int unsigned       col_pos;
  logic [CFG_W-1:0]  side_reg;
  blur_out_t         blur_due [$];
  string             field_names [7] = '{"out_red", "out_green", "out_blue", "out_row",
                                         "out_col", "last_of_run", "frame_done"};

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string line);
    $display("%0t ns: mismatch: %s", $time, line);
    errors++;
  endtask

  function automatic sum3_t window_sum(input bit with_left, input bit drop_top);
    sum3_t s;
    s = '0;
    for (int k = with_left ? 0 : 1; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        s[i] = s[i] + col_sums[k][i];
        if (drop_top) begin
          s[i] = s[i] - top_rows[k][i];
        end
      end
    end
    return s;
  endfunction

  function automatic blur_out_t blur_mean(input sum3_t s, input int unsigned div,
                                          input int unsigned r, input int unsigned c,
                                          input bit done);
    blur_out_t o;
    o.red   = FIELD_W'(s[CH_RED] / div);
    o.green = FIELD_W'(s[CH_GREEN] / div);
    o.blue  = FIELD_W'(s[CH_BLUE] / div);
    o.row   = POS_W'(r);
    o.col   = POS_W'(c);
    o.last  = 1'b0;
    o.done  = done;
    return o;
  endfunction

  task automatic apply_pixel(input rgb_t px);
    int unsigned d;
    int unsigned r;
    int unsigned c;
    int unsigned rows;
    int unsigned ncol;
    bit          full;
    rgb_t        above;
    rgb_t        above2;
    blur_out_t   batch [$];
    d = (side_reg < MIN_DIM) ? MIN_DIM : (side_reg > MAX_DIM) ? MAX_DIM : side_reg;
    r = row_pos;
    c = col_pos;
    if (r >= d || c >= d) begin
      r = 0;
      c = 0;
    end
    above  = (r >= 1) ? upper_line[c] : '0;
    above2 = (r >= 2) ? upper2_line[c] : '0;
    upper2_line[c] = upper_line[c];
    upper_line[c]  = px;
    col_sums[0] = col_sums[1];
    col_sums[1] = col_sums[2];
    top_rows[0] = top_rows[1];
    top_rows[1] = top_rows[2];
    for (int i = 0; i < 3; i++) begin
      col_sums[2][i] = 32'(px[i]) + 32'(above[i]) + 32'(above2[i]);
      top_rows[2][i] = 32'(above2[i]);
    end
    if (r >= 1 && c >= 1) begin
      rows = (r >= 2) ? 3 : 2;
      full = (c >= 2);
      ncol = full ? 3 : 2;
      batch.push_back(blur_mean(window_sum(full, 1'b0), rows * ncol, r - 1, c - 1, 1'b0));
      if (c == d - 1) begin
        batch.push_back(blur_mean(window_sum(1'b0, 1'b0), rows * 2, r - 1, d - 1, 1'b0));
      end
      if (r == d - 1) begin
        batch.push_back(blur_mean(window_sum(full, 1'b1), 2 * ncol, r, c - 1, 1'b0));
        if (c == d - 1) begin
          batch.push_back(blur_mean(window_sum(1'b0, 1'b1), 4, r, d - 1, 1'b1));
        end
      end
      batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) begin
        blur_due.push_back(batch[i]);
      end
    end
    c++;
    if (c >= d) begin
      c = 0;
      r++;
      if (r >= d) begin
        r = 0;
      end
    end
    row_pos = r;
    col_pos = c;
  endtask

  always @(posedge clk) begin : watch
    blur_out_t want;
    int        got_f [7];
    int        want_f [7];
    if (rst) begin
      side_reg = FRAME_DIM_RESET;
      row_pos  = 0;
      col_pos  = 0;
      for (int k = 0; k < 3; k++) begin
        col_sums[k] = '0;
        top_rows[k] = '0;
      end
      blur_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_FRAME_DIM, 2'b00}) begin
        side_reg = pwdata[CFG_W-1:0];
        row_pos  = 0;
        col_pos  = 0;
      end
      if (pixel.valid && pixel.ready) begin
        apply_pixel({pixel.in_blue, pixel.in_green, pixel.in_red});
      end
      if (result.valid && result.ready) begin
        if (blur_due.size() == 0) begin
          report_mismatch($sformatf("result item at row %0d col %0d with none due",
                                    result.out_row, result.out_col));
        end else begin
          want = blur_due.pop_front();
          got_f  = '{result.out_red, result.out_green, result.out_blue, result.out_row,
                     result.out_col, result.last_of_run, result.frame_done};
          want_f = '{want.red, want.green, want.blue, want.row, want.col, want.last,
                     want.done};
          for (int i = 0; i < 7; i++) begin
            if (got_f[i] != want_f[i]) begin
              report_mismatch($sformatf("%s at row %0d col %0d: got %0d, expected %0d",
                                        field_names[i], want.row, want.col, got_f[i],
                                        want_f[i]));
            end
          end
        end
      end
    end
    pending = blur_due.size();
  end

endmodule

FILE: sim/box_blur_3x3_clipped_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// box_blur_3x3_clipped_top_tb
// Streams RGB frames of many sides through the clipped 3x3 box blur, with
// random gaps on both channels, and gives the verdict from the checker.
// ============================================================================
module box_blur_3x3_clipped_top_tb;
  import bb3c_pkg::*;

  localparam int RANDOM_ITEMS  = 340;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 2000;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                pix_took = 1'b0;
  logic                cfg_took = 1'b0;
  bit                  src_gaps;
  bit                  snk_gaps;
  int                  errors;
  int                  pending;
  rgb_t                extreme_px [9];

  bb3c_pixel_if  pixel_ch ();
  bb3c_result_if result_ch ();

  box_blur_3x3_clipped_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixel   (pixel_ch),
    .result  (result_ch)
  );

  box_blur_3x3_clipped_checker i_check (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .pixel   (pixel_ch),
    .result  (result_ch),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    pix_took <= pixel_ch.valid && pixel_ch.ready;
    cfg_took <= psel && penable && pwrite && pready;
  end

  always @(negedge clk) begin
    result_ch.ready <= snk_gaps ? ($urandom_range(99) >= 13) : 1'b1;
  end

  function automatic logic [FIELD_W-1:0] random_channel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return FIELD_W'($urandom());
    endcase
  endfunction

  task automatic push_pixel(input rgb_t px);
    while (src_gaps && $urandom_range(99) < 13) begin
      pixel_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pixel_ch.valid    <= 1'b1;
    pixel_ch.in_red   <= px[CH_RED];
    pixel_ch.in_green <= px[CH_GREEN];
    pixel_ch.in_blue  <= px[CH_BLUE];
    do @(negedge clk); while (!pix_took);
  endtask

  task automatic stream_pixels(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      push_pixel({random_channel(), random_channel(), random_channel()});
    end
  endtask

  // Waits until every result item due has arrived, then lets the pipeline empty.
  task automatic settle();
    pixel_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_side(input logic [CFG_W-1:0] side);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_FRAME_DIM, 2'b00};
    pwdata  <= {(APB_DW - CFG_W)'($urandom()), side};
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!cfg_took);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (psel && penable && pwrite && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned fed;
    int unsigned count;
    int unsigned side;
    int unsigned phase;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    pixel_ch.valid     = 1'b0;
    pixel_ch.in_red    = '0;
    pixel_ch.in_green  = '0;
    pixel_ch.in_blue   = '0;
    result_ch.ready    = 1'b0;
    src_gaps           = 1'b1;
    snk_gaps           = 1'b1;
    extreme_px = '{{16'hFFFF, 16'hFFFF, 16'hFFFF}, {16'h0000, 16'h0000, 16'h0000},
                   {16'hAAAA, 16'h0000, 16'hFFFF}, {16'hFFFF, 16'hAAAA, 16'h5555},
                   {16'h0003, 16'h0002, 16'h0001}, {16'hFFFF, 16'hFFFF, 16'hFFFF},
                   {16'h0001, 16'h7FFF, 16'h8000}, {16'hFFFF, 16'hFFFF, 16'hFFFE},
                   {16'h8000, 16'hFFFF, 16'h0000}};
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A 3x3 frame covers the corners, the edges and the one interior pixel.
    write_side(CFG_W'(3));
    for (int i = 0; i < 9; i++) begin
      push_pixel(extreme_px[i]);
    end
    // Sides of 0 and 1 act as 2, where every pixel is a corner.
    settle();
    write_side(CFG_W'(0));
    for (int i = 0; i < 4; i++) begin
      push_pixel(extreme_px[i]);
    end
    settle();
    write_side(CFG_W'(1));
    for (int i = 0; i < 8; i++) begin
      push_pixel(extreme_px[8 - i]);
    end

    fed   = 0;
    phase = 0;
    while (fed < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0:       side = $urandom_range(1);
        1, 2:    side = $urandom_range(9, 16);
        default: side = $urandom_range(2, 8);
      endcase
      if (phase == 0) begin
        side = 8;
      end
      count = (side < 2) ? $urandom_range(4, 10)
                         : $urandom_range(side * side, 2 * side * side + side);
      if (phase == 0) begin
        count = 192;
      end
      if (count > RANDOM_ITEMS - fed) begin
        count = RANDOM_ITEMS - fed;
      end
      src_gaps = (phase != 0);
      snk_gaps = (phase != 0);
      settle();
      write_side(CFG_W'(side));
      if (phase == 2) begin
        stream_pixels(count / 2);
        settle();
        stream_pixels(count - count / 2);
      end else begin
        stream_pixels(count);
      end
      fed += count;
      phase++;
    end

    // The largest side and a side above it start row 0, then a small frame restarts.
    settle();
    write_side(CFG_W'(MAX_DIM));
    stream_pixels(30);
    settle();
    write_side(CFG_W'(2047));
    stream_pixels(30);
    settle();
    write_side(CFG_W'(4));
    stream_pixels(40);

    settle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
